### src/assert_macros.svh
// Assertion macros shared by the allocator RTL files.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition is true at every clock edge outside reset.
`define FFA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/ffa_pkg.sv
// Package for the first-fit free list allocator.
// Holds the sequencer state types, status codes and field widths; no dependencies.
`default_nettype none
package ffa_pkg;

  localparam int unsigned SIZE_W = 13;
  localparam int unsigned OFF_W  = 12;
  localparam int unsigned NEED_W = 14;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE   = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_A_RD,
    S_A_CMP,
    S_D_RD,
    S_D_WR,
    S_BUMP,
    S_F_RD,
    S_F_CMP,
    S_U_CHK,
    S_U_RD,
    S_U_WR,
    S_INS,
    S_M_RD,
    S_M_CMP,
    S_M_FL
  } seq_state_e;

  typedef enum logic {
    PH_WORK,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [OFF_W-1:0]  granted;
    logic [1:0]        status;
    logic [6:0]        free_entries;
    logic [SIZE_W-1:0] bytes_used;
  } result_t;

endpackage
`default_nettype wire

### src/ffa_mem.sv
// Free run table storage: one write port and one registered read port.
// Each word packs a run start offset and a run length; uses ffa_pkg widths.
`default_nettype none
module ffa_mem
  import ffa_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  wire logic [OFF_W+SIZE_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr_i,
  output      logic [OFF_W+SIZE_W-1:0]        rdata_o
);

  logic [OFF_W+SIZE_W-1:0] mem [DEPTH];
  logic [OFF_W+SIZE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/ffa_seq.sv
// Sequencer for the allocator: scans, shifts and merges the free run table
// one entry per step. Uses ffa_pkg.
`default_nettype none
`include "assert_macros.svh"
module ffa_seq
  import ffa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned FREE_SLOTS = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic                                cmd_i,
  input  wire logic [SIZE_W-1:0]                   size_i,
  input  wire logic [OFF_W-1:0]                    offset_i,
  output      logic                                idle_o,
  output      logic                                res_valid_o,
  input  wire logic                                res_take_i,
  output      result_t                             res_o,
  output      logic                                mem_we_o,
  output      logic [$clog2(FREE_SLOTS)-1:0]       mem_waddr_o,
  output      logic [OFF_W+SIZE_W-1:0]             mem_wdata_o,
  output      logic [$clog2(FREE_SLOTS)-1:0]       mem_raddr_o,
  input  wire logic [OFF_W+SIZE_W-1:0]             mem_rdata_i
);

  localparam int unsigned IDX_W = $clog2(FREE_SLOTS);
  localparam int unsigned CNT_W = $clog2(FREE_SLOTS + 1);

  seq_state_e        state_q, state_d;
  phase_e            phase_q;
  logic              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFF_W-1:0]  off_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  wr_q;
  logic [SIZE_W-1:0] top_q;
  logic [OFF_W-1:0]  acc_start_q;
  logic [SIZE_W-1:0] acc_len_q;
  logic              has_q;
  logic [OFF_W-1:0]  granted_q;
  logic [1:0]        status_q;

  logic [NEED_W-1:0] need;
  logic [OFF_W-1:0]  rd_start;
  logic [SIZE_W-1:0] rd_len;
  logic              fits;
  logic              exact;
  logic              lt;
  logic              touch;
  logic              a_bad;
  logic              a_nospace;
  logic              r_bad;
  logic              r_full;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_dec;
  logic              go_done;

  assign need      = NEED_W'(size_q) + NEED_W'(1);
  assign rd_start  = mem_rdata_i[OFF_W+SIZE_W-1:SIZE_W];
  assign rd_len    = mem_rdata_i[SIZE_W-1:0];
  assign fits      = NEED_W'(rd_len) >= need;
  assign exact     = NEED_W'(rd_len) == need;
  assign lt        = rd_start < off_q;
  assign touch     = (NEED_W'(acc_start_q) + NEED_W'(acc_len_q)) == NEED_W'(rd_start);
  assign a_bad     = (size_q == '0) || (32'(size_q) > 32'(PAGE_BYTES));
  assign a_nospace = (32'(top_q) + 32'(size_q)) >= 32'(PAGE_BYTES);
  assign r_bad     = (size_q == '0) || ((32'(off_q) + 32'(need)) > 32'(PAGE_BYTES));
  assign r_full    = 32'(cnt_q) >= 32'(FREE_SLOTS);
  assign idx_inc   = idx_q + CNT_W'(1);
  assign idx_dec   = idx_q - CNT_W'(1);

  always_comb begin
    state_d = state_q;
    go_done = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (phase_q == PH_WORK && start_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (a_bad || a_nospace) begin
            go_done = 1'b1;
          end else if (cnt_q == '0) begin
            state_d = S_BUMP;
          end else begin
            state_d = S_A_RD;
          end
        end else begin
          if (r_bad || r_full) begin
            go_done = 1'b1;
          end else if (cnt_q == '0) begin
            state_d = S_INS;
          end else begin
            state_d = S_F_RD;
          end
        end
      end
      S_A_RD:  state_d = S_A_CMP;
      S_A_CMP: begin
        if (fits) begin
          if (!exact) begin
            go_done = 1'b1;
          end else if (idx_inc < cnt_q) begin
            state_d = S_D_RD;
          end else begin
            go_done = 1'b1;
          end
        end else if (idx_inc < cnt_q) begin
          state_d = S_A_RD;
        end else begin
          state_d = S_BUMP;
        end
      end
      S_D_RD:  state_d = S_D_WR;
      S_D_WR: begin
        if (idx_inc < cnt_q) begin
          state_d = S_D_RD;
        end else begin
          go_done = 1'b1;
        end
      end
      S_BUMP:  go_done = 1'b1;
      S_F_RD:  state_d = S_F_CMP;
      S_F_CMP: begin
        if (lt && idx_inc < cnt_q) begin
          state_d = S_F_RD;
        end else begin
          state_d = S_U_CHK;
        end
      end
      S_U_CHK: begin
        if (idx_q > wr_q) begin
          state_d = S_U_RD;
        end else begin
          state_d = S_INS;
        end
      end
      S_U_RD:  state_d = S_U_WR;
      S_U_WR:  state_d = S_U_CHK;
      S_INS:   state_d = S_M_RD;
      S_M_RD:  state_d = S_M_CMP;
      S_M_CMP: begin
        if (idx_inc == cnt_q) begin
          state_d = S_M_FL;
        end else begin
          state_d = S_M_RD;
        end
      end
      S_M_FL:  go_done = 1'b1;
      default: state_d = S_IDLE;
    endcase
    if (go_done) begin
      state_d = S_IDLE;
    end
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[IDX_W-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = idx_q[IDX_W-1:0];
    case (state_q)
      S_D_RD: mem_raddr_o = idx_inc[IDX_W-1:0];
      S_U_RD: mem_raddr_o = idx_dec[IDX_W-1:0];
      S_A_CMP: begin
        mem_we_o    = fits && !exact;
        mem_wdata_o = {rd_start + OFF_W'(need), rd_len - SIZE_W'(need)};
      end
      S_D_WR:  mem_we_o = 1'b1;
      S_U_WR:  mem_we_o = 1'b1;
      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = wr_q[IDX_W-1:0];
        mem_wdata_o = {off_q, SIZE_W'(need)};
      end
      S_M_CMP: begin
        mem_we_o    = has_q && !touch;
        mem_waddr_o = wr_q[IDX_W-1:0];
        mem_wdata_o = {acc_start_q, acc_len_q};
      end
      S_M_FL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = wr_q[IDX_W-1:0];
        mem_wdata_o = {acc_start_q, acc_len_q};
      end
      default: mem_we_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_WORK;
      cnt_q   <= '0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      if (go_done) begin
        phase_q <= PH_DONE;
      end else if (phase_q == PH_DONE && res_take_i) begin
        phase_q <= PH_WORK;
      end
      case (state_q)
        S_A_CMP: begin
          if (fits && exact) begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        S_BUMP:  top_q <= top_q + SIZE_W'(need);
        S_INS:   cnt_q <= cnt_q + CNT_W'(1);
        S_M_FL:  cnt_q <= wr_q + CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q     <= cmd_i;
        size_q    <= size_i;
        off_q     <= offset_i;
        idx_q     <= '0;
        wr_q      <= '0;
        has_q     <= 1'b0;
      end
      S_CHECK: begin
        granted_q <= '0;
        status_q  <= ST_OK;
        if (cmd_q == CMD_ALLOC) begin
          if (a_bad) begin
            status_q <= ST_BAD_SIZE;
          end else if (a_nospace) begin
            status_q <= ST_NO_SPACE;
          end
        end else if (r_bad) begin
          status_q <= ST_BAD_SIZE;
        end else if (r_full) begin
          status_q <= ST_TABLE_FULL;
        end
      end
      S_A_CMP: begin
        if (fits) begin
          granted_q <= rd_start;
        end else begin
          idx_q <= idx_inc;
        end
      end
      S_D_WR:  idx_q <= idx_inc;
      S_BUMP:  granted_q <= top_q[OFF_W-1:0];
      S_F_CMP: begin
        if (lt) begin
          wr_q <= idx_inc;
          if (idx_inc < cnt_q) begin
            idx_q <= idx_inc;
          end else begin
            idx_q <= cnt_q;
          end
        end else begin
          wr_q  <= idx_q;
          idx_q <= cnt_q;
        end
      end
      S_U_WR:  idx_q <= idx_dec;
      S_INS: begin
        idx_q <= '0;
        wr_q  <= '0;
        has_q <= 1'b0;
      end
      S_M_CMP: begin
        idx_q <= idx_inc;
        if (has_q && touch) begin
          acc_len_q <= acc_len_q + rd_len;
        end else begin
          if (has_q) begin
            wr_q <= wr_q + CNT_W'(1);
          end
          acc_start_q <= rd_start;
          acc_len_q   <= rd_len;
          has_q       <= 1'b1;
        end
      end
      default: idx_q <= idx_q;
    endcase
  end

  assign idle_o      = (state_q == S_IDLE) && (phase_q == PH_WORK);
  assign res_valid_o = (phase_q == PH_DONE);
  assign res_o       = '{granted: granted_q, status: status_q,
                         free_entries: 7'(cnt_q), bytes_used: top_q};

  `FFA_ASSERT_ALWAYS(a_cnt_bound, 32'(cnt_q) <= 32'(FREE_SLOTS))
  `FFA_ASSERT_ALWAYS(a_top_bound, 32'(top_q) <= 32'(PAGE_BYTES))
  `FFA_ASSERT_NEXT(a_start_leaves_idle, idle_o && start_i, state_q == S_CHECK)

endmodule
`default_nettype wire

### src/first_fit_free_list_allocator_top.sv
// Top level of the first-fit free list allocator.
// Uses ffa_pkg, ffa_seq and ffa_mem.
//
// Usage: the input channel (in_valid_i / in_ready_o) carries one request per
// transaction: command_i selects allocate or release, request_size_i gives the
// payload size and release_offset_i the run offset for a release. Each request
// yields exactly one result transaction on the output channel
// (out_valid_o / out_ready_i) with the granted offset, status, free table
// entry count and top pointer usage.
// Flow: a rejected request ends in the check state. An allocate scans the table
// entry by entry (read, compare), then shifts the later entries down after an
// exact fit (read, write) or bumps the top pointer. A release scans for its
// slot (read, compare), shifts entries up (check, read, write), inserts the new
// run and merges touching runs in one pass (read, compare) with a final flush.
// One request is in work at a time; in_ready_o is high only while the sequencer
// is idle.
// Reset clears the table count and top pointer; no clearing pass is needed.
// While the receiver stalls with a full output register, the finished result
// waits in the sequencer and no new request is taken.
`default_nettype none
`include "assert_macros.svh"
module first_fit_free_list_allocator_top
  import ffa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned FREE_SLOTS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              command_i,
  input  wire logic [SIZE_W-1:0] request_size_i,
  input  wire logic [OFF_W-1:0]  release_offset_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [OFF_W-1:0]  granted_offset_o,
  output      logic [1:0]        status_o,
  output      logic [6:0]        free_entries_o,
  output      logic [SIZE_W-1:0] bytes_used_o
);

  localparam int unsigned IDX_W = $clog2(FREE_SLOTS);

  logic                    idle;
  logic                    res_valid;
  logic                    res_take;
  result_t                 res;
  result_t                 out_q;
  logic                    out_valid_q;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [IDX_W-1:0]        mem_raddr;
  logic [OFF_W+SIZE_W-1:0] mem_wdata;
  logic [OFF_W+SIZE_W-1:0] mem_rdata;

  assign in_ready_o = idle;
  assign res_take   = res_valid && (!out_valid_q || out_ready_i);

  ffa_seq #(
    .PAGE_BYTES(PAGE_BYTES),
    .FREE_SLOTS(FREE_SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .cmd_i       (command_i),
    .size_i      (request_size_i),
    .offset_i    (release_offset_i),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ffa_mem #(
    .DEPTH(FREE_SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_offset_o = out_q.granted;
  assign status_o         = out_q.status;
  assign free_entries_o   = out_q.free_entries;
  assign bytes_used_o     = out_q.bytes_used;

  `FFA_ASSERT_NEXT(a_take_fills_out, res_take, out_valid_q)
  `FFA_ASSERT_ALWAYS(a_no_write_idle, !(idle && mem_we))
  `FFA_ASSERT_ALWAYS(a_no_take_idle, !(idle && res_valid))

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_free_list_allocator_top.
// Drives directed rows then random allocate and release traffic; checks each result
// against typed rows or an in-bench free table model; depends on ffa_pkg, RTL only.
module tb
  import ffa_pkg::*;
;

  localparam int PAGE = 4096;
  localparam int SLOTS = 64;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic    cmd;
    int      size;
    int      offset;
    bit      typed;
    result_t res;
  } stim_row_t;

  typedef struct {
    int offset;
    int size;
  } live_run_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              command = CMD_ALLOC;
  logic [SIZE_W-1:0] request_size = '0;
  logic [OFF_W-1:0]  release_offset = '0;
  logic              out_ready = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [OFF_W-1:0]  granted_offset_o;
  logic [1:0]        status_o;
  logic [6:0]        free_entries_o;
  logic [SIZE_W-1:0] bytes_used_o;

  int        run_start [SLOTS];
  int        run_len [SLOTS];
  int        entry_count = 0;
  int        top_ptr = 0;
  int        used_total = 0;
  result_t   pending_results[$];
  live_run_t live_runs[$];
  stim_row_t plan[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        quiet = 1'b0;

  first_fit_free_list_allocator_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o),
    .command_i(command), .request_size_i(request_size),
    .release_offset_i(release_offset),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready),
    .granted_offset_o(granted_offset_o), .status_o(status_o),
    .free_entries_o(free_entries_o), .bytes_used_o(bytes_used_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic result_t allocate_run(int size);
    result_t r;
    int need;
    r = '0;
    need = size + 1;
    if (size == 0 || size > PAGE) begin
      r.status = ST_BAD_SIZE;
    end else if (top_ptr + size >= PAGE) begin
      r.status = ST_NO_SPACE;
    end else begin
      r.status = ST_OK;
      for (int i = 0; i < entry_count; i++) begin
        if (run_len[i] >= need) begin
          r.granted = run_start[i][OFF_W-1:0];
          if (run_len[i] > need) begin
            run_len[i] -= need;
            run_start[i] += need;
          end else begin
            for (int k = i; k + 1 < entry_count; k++) begin
              run_start[k] = run_start[k+1];
              run_len[k] = run_len[k+1];
            end
            entry_count--;
          end
          return r;
        end
      end
      r.granted = top_ptr[OFF_W-1:0];
      top_ptr += need;
      used_total += need;
    end
    return r;
  endfunction

  function automatic logic [1:0] release_run(int size, int offset);
    int need;
    int pos;
    int wr;
    need = size + 1;
    pos = 0;
    if (size == 0 || offset + need > PAGE) return ST_BAD_SIZE;
    if (entry_count >= SLOTS) return ST_TABLE_FULL;
    while (pos < entry_count && run_start[pos] < offset) pos++;
    for (int k = entry_count; k > pos; k--) begin
      run_start[k] = run_start[k-1];
      run_len[k] = run_len[k-1];
    end
    run_start[pos] = offset;
    run_len[pos] = need;
    entry_count++;
    wr = 0;
    for (int rd = 0; rd < entry_count; rd++) begin
      if (wr > 0 && run_start[wr-1] + run_len[wr-1] == run_start[rd]) begin
        run_len[wr-1] += run_len[rd];
      end else begin
        run_start[wr] = run_start[rd];
        run_len[wr] = run_len[rd];
        wr++;
      end
    end
    entry_count = wr;
    return ST_OK;
  endfunction

  function automatic result_t predict_result(logic cmd, int size, int offset);
    result_t r;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      r = allocate_run(size);
      if (r.status == ST_OK) live_runs.push_back('{offset: r.granted, size: size});
    end else begin
      r.status = release_run(size, offset);
    end
    r.free_entries = entry_count[6:0];
    r.bytes_used = used_total[SIZE_W-1:0];
    return r;
  endfunction

  function automatic void add_row(logic cmd, int size, int offset, bit typed,
                                  logic [1:0] st, int granted, int fe, int used);
    stim_row_t row;
    row.cmd = cmd;
    row.size = size;
    row.offset = offset;
    row.typed = typed;
    row.res.granted = granted[OFF_W-1:0];
    row.res.status = st;
    row.res.free_entries = fe[6:0];
    row.res.bytes_used = used[SIZE_W-1:0];
    plan.push_back(row);
  endfunction

  task automatic report(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic send(logic cmd, int size, int offset, bit typed, result_t tres);
    int gap;
    result_t p;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command <= cmd;
    request_size <= size[SIZE_W-1:0];
    release_offset <= offset[OFF_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_result(cmd, size & 32'h1FFF, offset & 32'hFFF);
    pending_results.push_back(typed ? tres : p);
  endtask

  task automatic send_random();
    int pick;
    int idx;
    live_run_t lr;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send(1'($urandom_range(0, 1)), $urandom_range(0, 8191), $urandom_range(0, 4095), 0, '0);
    end else if (pick < 55 || live_runs.size() == 0) begin
      send(CMD_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300)
                                                  : $urandom_range(1, 8), 0, 0, '0);
    end else begin
      idx = $urandom_range(0, live_runs.size() - 1);
      lr = live_runs[idx];
      live_runs.delete(idx);
      send(CMD_RELEASE, lr.size, lr.offset, 0, '0);
    end
  endtask

  initial begin
    int gap;
    result_t got;
    result_t want;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.granted = granted_offset_o;
      got.status = status_o;
      got.free_entries = free_entries_o;
      got.bytes_used = bytes_used_o;
      if (pending_results.size() == 0) begin
        report("unexpected result transaction", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.granted !== want.granted) report("granted_offset", got.granted, want.granted);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.free_entries !== want.free_entries)
          report("free_entries", got.free_entries, want.free_entries);
        if (got.bytes_used !== want.bytes_used)
          report("bytes_used", got.bytes_used, want.bytes_used);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("first_fit_free_list_allocator_top regression: fail");
      $finish;
    end
  end

  initial begin
    add_row(CMD_ALLOC, 0, 0, 1, ST_BAD_SIZE, 0, 0, 0);
    add_row(CMD_ALLOC, 4097, 0, 1, ST_BAD_SIZE, 0, 0, 0);
    add_row(CMD_ALLOC, 8191, 4095, 1, ST_BAD_SIZE, 0, 0, 0);
    add_row(CMD_RELEASE, 0, 100, 1, ST_BAD_SIZE, 0, 0, 0);
    add_row(CMD_RELEASE, 1, 4095, 1, ST_BAD_SIZE, 0, 0, 0);
    add_row(CMD_ALLOC, 4096, 0, 1, ST_NO_SPACE, 0, 0, 0);
    add_row(CMD_ALLOC, 10, 0, 1, ST_OK, 0, 0, 11);
    add_row(CMD_ALLOC, 20, 0, 1, ST_OK, 11, 0, 32);
    add_row(CMD_ALLOC, 5, 0, 1, ST_OK, 32, 0, 38);
    add_row(CMD_RELEASE, 20, 11, 1, ST_OK, 0, 1, 38);
    add_row(CMD_ALLOC, 20, 0, 1, ST_OK, 11, 0, 38);
    add_row(CMD_RELEASE, 20, 11, 1, ST_OK, 0, 1, 38);
    add_row(CMD_ALLOC, 19, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_ALLOC, 1, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_RELEASE, 9, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_RELEASE, 20, 10, 0, ST_OK, 0, 0, 0);
    add_row(CMD_RELEASE, 1, 4094, 0, ST_OK, 0, 0, 0);
    add_row(CMD_RELEASE, 3, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_ALLOC, 4000, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_ALLOC, 2, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_ALLOC, 60, 0, 0, ST_OK, 0, 0, 0);
    add_row(CMD_RELEASE, 4094, 1, 0, ST_OK, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) send(plan[i].cmd, plan[i].size, plan[i].offset, plan[i].typed, plan[i].res);
    live_runs.delete();
    for (int i = 0; i < 2000; i++) begin
      quiet = ((i % 250) >= 200);
      if (i == 1000) begin
        for (int k = 0; k < 80; k++) send(CMD_RELEASE, 1, 3 * $urandom_range(0, 1364), 0, '0);
      end
      send_random();
    end
    @(posedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("first_fit_free_list_allocator_top regression: pass");
    end else begin
      $display("first_fit_free_list_allocator_top regression: fail");
    end
    $finish;
  end
endmodule
